>>> design/eepc_pkg.sv
// types and constants shared by the encoder edge period capture block
package eepc_pkg;

    localparam int KIND_W     = 2;
    localparam int APB_ADDR_W = 3;

    // event codes
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CAPTURE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd2;

    // register index, taken from paddr above the byte offset
    localparam logic [APB_ADDR_W-3:0] REG_TIMER_TOP = 1'b0;

    localparam logic [15:0] TOP_RESET = 16'hFFFF;

    // one channel's state as held in the memory
    typedef struct packed {
        logic [31:0] since;
        logic [31:0] total;
        logic [15:0] prev;
        logic [31:0] edges;
        logic        rising;
    } t_chan_state;

    localparam int STATE_W = $bits(t_chan_state);

    // operands handed from the update stage to the arithmetic stage
    typedef struct packed {
        logic        dv;
        logic [15:0] cap;
        logic [31:0] since;
        logic [15:0] prev;
        logic [31:0] total;
        logic [15:0] tcnt;
        logic [31:0] edges;
        logic        rising;
    } t_calc;

endpackage

>>> design/eepc_ifs.sv
// event and result channel interfaces
interface eepc_ev_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        channel;
    logic [15:0] capture_value;
    logic [15:0] timer_count;

    modport source (output valid, kind, channel, capture_value, timer_count, input ready);
    modport sink   (input valid, kind, channel, capture_value, timer_count, output ready);
endinterface

interface eepc_res_if;
    logic        valid;
    logic        ready;
    logic        delta_valid;
    logic [31:0] interval_ticks;
    logic [31:0] edge_total;
    logic [31:0] elapsed_ticks;
    logic        next_edge_rising;

    modport source (output valid, delta_valid, interval_ticks, edge_total, elapsed_ticks,
                    next_edge_rising, input ready);
    modport sink   (input valid, delta_valid, interval_ticks, edge_total, elapsed_ticks,
                    next_edge_rising, output ready);
endinterface

>>> design/eepc_ram.sv
// generic single write port ram with registered read
module eepc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/eepc_apb.sv
// apb configuration register file holding the timer top value
module eepc_apb (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [eepc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [15:0]                     o_timer_top
);
    import eepc_pkg::*;

    logic [15:0]           r_timer_top;
    logic [APB_ADDR_W-3:0] w_reg_idx;
    logic                  w_wr;

    assign w_reg_idx = paddr[APB_ADDR_W-1:2];
    assign w_wr      = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_top <= TOP_RESET;
        end else if (w_wr && (w_reg_idx == REG_TIMER_TOP)) begin
            r_timer_top <= pwdata[15:0];
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_TIMER_TOP: prdata = {16'b0, r_timer_top};
            default:       prdata = '0;
        endcase
    end

    assign o_timer_top = r_timer_top;

endmodule

>>> design/eepc_arith.sv
// interval and elapsed tick arithmetic with the result output register
module eepc_arith (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  eepc_pkg::t_calc i_calc,
    input  logic [15:0]     i_timer_top,
    eepc_res_if.source      o_res
);
    import eepc_pkg::*;

    t_calc       r_s2;
    logic        r_s2_vld;
    logic        r_o_vld;
    logic        r_o_dv;
    logic [31:0] r_o_interval;
    logic [31:0] r_o_edges;
    logic [31:0] r_o_elapsed;
    logic        r_o_rising;
    logic        w_s2_adv;
    logic [16:0] w_period;
    logic [31:0] w_since_prod;
    logic [31:0] w_total_prod;

    assign w_s2_adv = r_s2_vld && (!r_o_vld || o_res.ready);
    assign o_ready  = !r_s2_vld || w_s2_adv;

    // period formed in 17 bits so a top of all ones gives 2^16
    assign w_period     = 17'(i_timer_top) + 17'd1;
    assign w_since_prod = r_s2.since * 32'(w_period);
    assign w_total_prod = r_s2.total * 32'(w_period);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s2_vld <= i_valid;
            end
            if (w_s2_adv) begin
                r_o_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s2 <= i_calc;
        end
        if (w_s2_adv) begin
            r_o_dv       <= r_s2.dv;
            r_o_interval <= 32'(r_s2.cap) + w_since_prod - 32'(r_s2.prev);
            r_o_edges    <= r_s2.edges;
            r_o_elapsed  <= w_total_prod + 32'(r_s2.tcnt);
            r_o_rising   <= r_s2.rising;
        end
    end

    assign o_res.valid            = r_o_vld;
    assign o_res.delta_valid      = r_o_dv;
    assign o_res.interval_ticks   = r_o_interval;
    assign o_res.edge_total       = r_o_edges;
    assign o_res.elapsed_ticks    = r_o_elapsed;
    assign o_res.next_edge_rising = r_o_rising;

endmodule

>>> design/encoder_edge_period_capture_unit.sv
// encoder edge period capture unit: top level
//
// One event transfer per clock unless the result side stalls: a timer overflow, a capture
// edge or a channel clear for one encoder channel. Each accepted event yields exactly one
// result via the update, arithmetic and output registers while later events enter behind. All
// per-channel counters (overflows since the last edge, total overflows, last capture, edge
// count, armed polarity) live in one memory word per channel; the sustained rate of one event
// per cycle is set by its single read and single write port, with a one-entry forward of the
// word being written so back-to-back events on the same channel see fresh state. Per-entry
// valid bits make a never-written channel read as all zero, so no clearing pass follows
// reset. The period is timer_top + 1 in 17 bits; the two products with it sit in their own
// stage ahead of the output register. Events on a channel at or beyond CHANNELS change
// nothing and return an all-zero result.
module encoder_edge_period_capture_unit #(
    parameter int CHANNELS = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [eepc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    eepc_ev_if.sink                         i_ev,
    eepc_res_if.source                      o_res
);
    import eepc_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration
    logic [15:0] w_timer_top;

    // input side
    logic          w_in_acc;
    logic [AW-1:0] w_in_idx;
    logic          w_in_oor;

    // update stage: event fields plus the memory word read at acceptance
    logic              r_s1_vld;
    logic [KIND_W-1:0] r_s1_kind;
    logic              r_s1_oor;
    logic [AW-1:0]     r_s1_idx;
    logic [15:0]       r_s1_cap;
    logic [15:0]       r_s1_tcnt;
    logic              r_s1_evld;
    logic              r_s1_fwd;
    logic              w_s1_adv;
    logic              w_s1_ready;
    logic              w_s2_ready;

    // state memory, valid bits and forward register
    logic [CHANNELS-1:0] r_ent_vld;
    logic [STATE_W-1:0]  w_ram_rdata;
    logic                w_ram_we;
    t_chan_state         r_fwd_data;
    logic [AW-1:0]       r_fwd_idx;
    t_chan_state         w_cur;
    t_chan_state         n_state;
    t_calc               w_calc;

    eepc_apb u_apb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_timer_top (w_timer_top)
    );

    // accept whenever the update stage is empty or moving on
    assign w_s1_ready  = !r_s1_vld || w_s2_ready;
    assign i_ev.ready  = w_s1_ready;
    assign w_in_acc    = i_ev.valid && w_s1_ready;
    assign w_in_idx    = AW'(i_ev.channel);
    assign w_in_oor    = int'(i_ev.channel) >= CHANNELS;
    assign w_s1_adv    = r_s1_vld && w_s2_ready;
    // out-of-range channels leave the memory untouched
    assign w_ram_we    = w_s1_adv && !r_s1_oor;

    eepc_ram #(
        .WIDTH (STATE_W),
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_s1_idx),
        .i_wdata (n_state),
        .i_re    (w_in_acc),
        .i_raddr (w_in_idx),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s1_fwd  <= 1'b0;
            r_s1_evld <= 1'b0;
            r_ent_vld <= '0;
        end else begin
            if (w_s1_ready) begin
                r_s1_vld <= i_ev.valid;
            end
            if (w_in_acc) begin
                // the write landing on this same edge is missed by the read
                r_s1_fwd  <= w_ram_we && (r_s1_idx == w_in_idx);
                r_s1_evld <= !w_in_oor && r_ent_vld[w_in_idx];
            end
            if (w_ram_we) begin
                r_ent_vld[r_s1_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_kind <= i_ev.kind;
            r_s1_oor  <= w_in_oor;
            r_s1_idx  <= w_in_idx;
            r_s1_cap  <= i_ev.capture_value;
            r_s1_tcnt <= i_ev.timer_count;
        end
        if (w_ram_we) begin
            r_fwd_data <= n_state;
            r_fwd_idx  <= r_s1_idx;
        end
    end

    // current channel state: forwarded word, memory word, or zero if never written
    always_comb begin
        if (r_s1_fwd) begin
            w_cur = r_fwd_data;
        end else if (r_s1_evld) begin
            w_cur = t_chan_state'(w_ram_rdata);
        end else begin
            w_cur = '0;
        end
    end

    // read-modify-write of the channel word
    always_comb begin
        n_state = w_cur;
        case (r_s1_kind)
            KIND_OVERFLOW: begin
                n_state.since = w_cur.since + 32'd1;
                n_state.total = w_cur.total + 32'd1;
            end
            KIND_CAPTURE: begin
                n_state.edges  = w_cur.edges + 32'd1;
                n_state.rising = !w_cur.rising;
                n_state.since  = '0;
                n_state.prev   = r_s1_cap;
            end
            KIND_CLEAR: begin
                // polarity survives a clear
                n_state.since = '0;
                n_state.total = '0;
                n_state.prev  = '0;
                n_state.edges = '0;
            end
            default: begin
            end
        endcase
    end

    // operands for the arithmetic stage; non-captures zero the interval terms
    always_comb begin
        w_calc = '0;
        if (!r_s1_oor) begin
            w_calc.dv     = (r_s1_kind == KIND_CAPTURE);
            w_calc.total  = n_state.total;
            w_calc.tcnt   = r_s1_tcnt;
            w_calc.edges  = n_state.edges;
            w_calc.rising = n_state.rising;
            if (r_s1_kind == KIND_CAPTURE) begin
                w_calc.cap   = r_s1_cap;
                w_calc.since = w_cur.since;
                w_calc.prev  = w_cur.prev;
            end
        end
    end

    eepc_arith u_arith (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_vld),
        .o_ready     (w_s2_ready),
        .i_calc      (w_calc),
        .i_timer_top (w_timer_top),
        .o_res       (o_res)
    );

    // a forwarded word must belong to the channel being updated
    a_fwd_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_fwd) |-> (r_fwd_idx == r_s1_idx))
        else $error("forwarded state from a different channel");

    // an out-of-range event never writes the state memory
    a_oor_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_oor) |-> !w_ram_we)
        else $error("state write for out-of-range channel");

    // every write marks its entry valid on the next edge
    a_vld_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |=> r_ent_vld[$past(r_s1_idx)])
        else $error("entry valid bit not set after write");

endmodule

>>> dv/testbench.sv
// self-checking testbench for the encoder edge period capture unit
`timescale 1ns / 100ps

module testbench;
    import eepc_pkg::*;

    localparam int NUM_CHANNELS   = 2;
    localparam int PHASE_ITEMS    = 165;
    localparam int SQUEEZE_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 2000;

    // kind code that the block must treat as a status query
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
    localparam logic [APB_ADDR_W-1:0] TOP_ADDR = {REG_TIMER_TOP, 2'b00};

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              channel;
        logic [15:0]       capture_value;
        logic [15:0]       timer_count;
    } t_enc_ev;

    typedef struct packed {
        logic        delta_valid;
        logic [31:0] interval_ticks;
        logic [31:0] edge_total;
        logic [31:0] elapsed_ticks;
        logic        next_edge_rising;
    } t_enc_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    eepc_ev_if  ev_bus ();
    eepc_res_if res_bus ();

    encoder_edge_period_capture_unit #(
        .CHANNELS (NUM_CHANNELS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_ev    (ev_bus),
        .o_res   (res_bus)
    );

    // per-channel shadow of the capture state and the programmed timer top
    logic [15:0] top_setting;
    logic [31:0] ovf_since_edge [NUM_CHANNELS];
    logic [31:0] ovf_total      [NUM_CHANNELS];
    logic [15:0] last_capture   [NUM_CHANNELS];
    logic [31:0] edge_count     [NUM_CHANNELS];
    logic        armed_rising   [NUM_CHANNELS];

    t_enc_ev  pending_events [$];
    t_enc_res expected_results [$];

    int          fail_count   = 0;
    int unsigned send_gap;
    int unsigned recv_gap;
    int unsigned recv_draw;
    int unsigned quiet_cycles;
    bit          send_idle    = 1'b1;
    bit          recv_idle    = 1'b1;
    bit          squeeze_req  = 1'b0;
    bit          squeeze_done;
    t_enc_ev     next_ev;
    t_enc_ev     seen_ev;
    t_enc_res    want_res;

    // clock, 4 ns period
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // one line per mismatch
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // applies one event to the shadow state and returns the result it should produce
    function automatic t_enc_res predict_capture_result(t_enc_ev ev);
        t_enc_res    r;
        logic [16:0] period;
        int unsigned c;
        r      = '0;
        period = {1'b0, top_setting} + 17'd1;
        c      = 32'(ev.channel);
        // a channel beyond the configured count changes nothing and reports zeros
        if (c >= NUM_CHANNELS)
            return r;
        case (ev.kind)
            KIND_OVERFLOW: begin
                ovf_since_edge[c] = ovf_since_edge[c] + 32'd1;
                ovf_total[c]      = ovf_total[c] + 32'd1;
            end
            KIND_CAPTURE: begin
                edge_count[c]   = edge_count[c] + 32'd1;
                armed_rising[c] = ~armed_rising[c];
                // interval wraps modulo 2^32 when the capture plus the overflow ticks is below the previous one
                r.interval_ticks = 32'(ev.capture_value) + ovf_since_edge[c] * 32'(period)
                                   - 32'(last_capture[c]);
                r.delta_valid     = 1'b1;
                ovf_since_edge[c] = '0;
                last_capture[c]   = ev.capture_value;
            end
            KIND_CLEAR: begin
                // polarity survives a clear
                ovf_since_edge[c] = '0;
                ovf_total[c]      = '0;
                last_capture[c]   = '0;
                edge_count[c]     = '0;
            end
            default: ;
        endcase
        r.edge_total       = edge_count[c];
        r.elapsed_ticks    = 32'(period) * ovf_total[c] + 32'(ev.timer_count);
        r.next_edge_rising = armed_rising[c];
        return r;
    endfunction

    task automatic queue_event(logic [KIND_W-1:0] kind, logic ch, logic [15:0] cap,
                               logic [15:0] tcnt);
        t_enc_ev ev;
        ev.kind          = kind;
        ev.channel       = ch;
        ev.capture_value = cap;
        ev.timer_count   = tcnt;
        pending_events.push_back(ev);
    endtask

    // timer values biased toward the extremes and toward the current period
    function automatic logic [15:0] pick_tick();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        if (r == 2)
            return top_setting;
        if (r < 6)
            return 16'($urandom_range(0, top_setting));
        return 16'($urandom);
    endfunction

    // sender pause: nothing queued, nothing offered, nothing outstanding, then a wait
    // for the three-stage pipeline to settle
    task automatic wait_for_drain();
        do
            @(negedge i_clk);
        while (pending_events.size() != 0 || ev_bus.valid || expected_results.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // apb write of the timer top, then a read back of the same register; the write's
    // access edge flows straight into the read's setup so psel is never toggled twice
    task automatic program_timer_top(logic [15:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TOP_ADDR;
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        top_setting = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== {16'h0000, value})
            report_mismatch("timer_top read back", prdata, {16'h0000, value});
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // event driver: holds an item until transfer, then waits its drawn gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ev_bus.valid <= 1'b0;
            send_gap     <= 0;
        end else if (!ev_bus.valid || ev_bus.ready) begin
            if (send_gap > 0) begin
                send_gap     <= send_gap - 1;
                ev_bus.valid <= 1'b0;
            end else if (pending_events.size() > 0) begin
                next_ev = pending_events.pop_front();
                ev_bus.kind          <= next_ev.kind;
                ev_bus.channel       <= next_ev.channel;
                ev_bus.capture_value <= next_ev.capture_value;
                ev_bus.timer_count   <= next_ev.timer_count;
                ev_bus.valid         <= 1'b1;
                send_gap             <= send_idle ? $urandom_range(0, 9) : 0;
            end else begin
                ev_bus.valid <= 1'b0;
            end
        end
    end

    // result receiver: per-transfer stall draw, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            recv_gap      <= 0;
            squeeze_done  <= 1'b0;
        end else if (squeeze_req && !squeeze_done) begin
            // long hold so the pipeline backs up and stalls the event side
            res_bus.ready <= 1'b0;
            recv_gap      <= SQUEEZE_CYCLES;
            squeeze_done  <= 1'b1;
        end else if (res_bus.valid && res_bus.ready) begin
            recv_draw = recv_idle ? $urandom_range(0, 9) : 0;
            res_bus.ready <= (recv_draw == 0);
            recv_gap      <= recv_draw;
        end else if (recv_gap > 0) begin
            recv_gap      <= recv_gap - 1;
            res_bus.ready <= (recv_gap == 1);
        end else begin
            res_bus.ready <= 1'b1;
        end
    end

    // monitor: predict on event transfer, check on result transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (ev_bus.valid && ev_bus.ready) begin
                seen_ev.kind          = ev_bus.kind;
                seen_ev.channel       = ev_bus.channel;
                seen_ev.capture_value = ev_bus.capture_value;
                seen_ev.timer_count   = ev_bus.timer_count;
                expected_results.push_back(predict_capture_result(seen_ev));
            end
            if (res_bus.valid && res_bus.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, edge_total", res_bus.edge_total, '0);
                end else begin
                    want_res = expected_results.pop_front();
                    if (res_bus.delta_valid !== want_res.delta_valid)
                        report_mismatch("delta_valid", 32'(res_bus.delta_valid),
                                        32'(want_res.delta_valid));
                    if (res_bus.interval_ticks !== want_res.interval_ticks)
                        report_mismatch("interval_ticks", res_bus.interval_ticks,
                                        want_res.interval_ticks);
                    if (res_bus.edge_total !== want_res.edge_total)
                        report_mismatch("edge_total", res_bus.edge_total, want_res.edge_total);
                    if (res_bus.elapsed_ticks !== want_res.elapsed_ticks)
                        report_mismatch("elapsed_ticks", res_bus.elapsed_ticks,
                                        want_res.elapsed_ticks);
                    if (res_bus.next_edge_rising !== want_res.next_edge_rising)
                        report_mismatch("next_edge_rising", 32'(res_bus.next_edge_rising),
                                        32'(want_res.next_edge_rising));
                end
            end
        end
    end

    // watchdog: too long without any transfer means the block is hung
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (ev_bus.valid && ev_bus.ready)
                || (res_bus.valid && res_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        logic [15:0] tops [8];
        int          queued;
        int          n;
        int          roll;
        logic        ch;

        // every input known from time zero
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        ev_bus.valid         = 1'b0;
        ev_bus.kind          = KIND_OVERFLOW;
        ev_bus.channel       = 1'b0;
        ev_bus.capture_value = '0;
        ev_bus.timer_count   = '0;
        res_bus.ready        = 1'b0;

        top_setting = TOP_RESET;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            ovf_since_edge[c] = '0;
            ovf_total[c]      = '0;
            last_capture[c]   = '0;
            edge_count[c]     = '0;
            armed_rising[c]   = 1'b0;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset period of 65536
        @(negedge i_clk);
        queue_event(KIND_UNKNOWN,  1'b0, 16'hFFFF, 16'hFFFF); // status of an untouched channel
        queue_event(KIND_CAPTURE,  1'b0, 16'hFFFF, 16'h0000); // first edge against zero
        queue_event(KIND_OVERFLOW, 1'b0, 16'h0000, 16'h1234);
        queue_event(KIND_OVERFLOW, 1'b0, 16'hFFFF, 16'h0000);
        queue_event(KIND_CAPTURE,  1'b0, 16'h0000, 16'hFFFF); // interval across two periods
        queue_event(KIND_CAPTURE,  1'b0, 16'h0001, 16'h8000);
        queue_event(KIND_CAPTURE,  1'b0, 16'h0000, 16'h0000); // interval wraps to all ones
        queue_event(KIND_OVERFLOW, 1'b1, 16'h5555, 16'hAAAA);
        queue_event(KIND_CAPTURE,  1'b1, 16'hAAAA, 16'h5555);
        queue_event(KIND_UNKNOWN,  1'b1, 16'h0000, 16'h0000);
        queue_event(KIND_CLEAR,    1'b1, 16'hFFFF, 16'hFFFF); // polarity must survive
        queue_event(KIND_CAPTURE,  1'b1, 16'h8000, 16'h7FFF);
        queue_event(KIND_OVERFLOW, 1'b0, 16'h7FFF, 16'hFFFF);
        queue_event(KIND_CLEAR,    1'b0, 16'h0000, 16'h0000);
        queue_event(KIND_UNKNOWN,  1'b0, 16'h1234, 16'hFFFF);
        wait_for_drain();

        // smallest period: one tick per overflow
        program_timer_top(16'h0000);
        @(negedge i_clk);
        queue_event(KIND_OVERFLOW, 1'b0, 16'h0000, 16'h0000);
        queue_event(KIND_OVERFLOW, 1'b0, 16'hFFFF, 16'hFFFF);
        queue_event(KIND_OVERFLOW, 1'b0, 16'h0000, 16'hFFFF);
        queue_event(KIND_CAPTURE,  1'b0, 16'hFFFF, 16'h0000);
        queue_event(KIND_OVERFLOW, 1'b1, 16'h0000, 16'h0001);
        queue_event(KIND_CAPTURE,  1'b1, 16'h0000, 16'h0000);
        queue_event(KIND_CLEAR,    1'b0, 16'hFFFF, 16'h0000);
        queue_event(KIND_CAPTURE,  1'b0, 16'h0000, 16'hFFFF);
        wait_for_drain();

        // random phases, each under its own timer top
        tops[0] = 16'h0001;
        tops[1] = 16'hFFFF;
        tops[2] = 16'hFFFE;
        tops[3] = 16'h00FF;
        tops[4] = 16'($urandom);
        tops[5] = 16'h8000;
        tops[6] = 16'($urandom);
        tops[7] = 16'h0000;

        for (int p = 0; p < 8; p++) begin
            program_timer_top(tops[p]);
            @(negedge i_clk);
            // mix of idling styles, including stretches with none on either side
            send_idle = (p % 3) != 1;
            recv_idle = (p % 3) != 2;
            if (p == 2) begin
                send_idle   = 1'b0;
                squeeze_req = 1'b1;
            end
            queued = 0;
            while (queued < PHASE_ITEMS) begin
                ch   = 1'($urandom_range(0, 1));
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    // well-formed run: a few overflows, now and then many, then the edge
                    n = $urandom_range(0, ($urandom_range(0, 7) == 0) ? 24 : 3);
                    repeat (n) queue_event(KIND_OVERFLOW, ch, pick_tick(), pick_tick());
                    queue_event(KIND_CAPTURE, ch, pick_tick(), pick_tick());
                    queued += n + 1;
                end else if (roll < 88) begin
                    queue_event(KIND_W'($urandom_range(0, 1)), ch, pick_tick(), pick_tick());
                    queued++;
                end else if (roll < 94) begin
                    queue_event(KIND_CLEAR, ch, pick_tick(), pick_tick());
                    queued++;
                end else begin
                    queue_event(KIND_UNKNOWN, ch, pick_tick(), pick_tick());
                    queued++;
                end
            end
            wait_for_drain();
        end

        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

>>> encoder_edge_period_capture_unit.f
design/eepc_pkg.sv
design/eepc_ifs.sv
design/eepc_ram.sv
design/eepc_apb.sv
design/eepc_arith.sv
design/encoder_edge_period_capture_unit.sv
dv/testbench.sv
